// File: hw/rtl/kli_pkg.sv
`default_nettype none
package kli_pkg;

	localparam int unsigned BLEND_W   = 17;
	localparam int unsigned DIV_STEPS = 17;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

	localparam logic [1:0] CASE_EMPTY   = 2'd0;
	localparam logic [1:0] CASE_SINGLE  = 2'd1;
	localparam logic [1:0] CASE_INTERP  = 2'd2;
	localparam logic [1:0] CASE_CLAMPED = 2'd3;

	localparam logic [1:0] CH_X     = 2'd0;
	localparam logic [1:0] CH_Y     = 2'd1;
	localparam logic [1:0] CH_ANGLE = 2'd2;

	localparam logic REG_FRAME_COUNT = 1'b0;

	typedef struct packed {
		logic               req_type;
		logic        [2:0]  frame_slot;
		logic signed [31:0] key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_angle;
		logic signed [31:0] query_time;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_time;
		logic signed [31:0] result_x;
		logic signed [31:0] result_y;
		logic signed [31:0] result_angle;
		logic        [1:0]  result_case;
	} result_t;

	typedef struct packed {
		logic signed [31:0] t;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] angle;
	} frame_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_GOT,
		ST_DIV,
		ST_MUL,
		ST_ADD
	} state_t;

endpackage
`default_nettype wire

// File: hw/rtl/keyframe_linear_interpolator_core.sv
// With no frames the result is registered straight from idle; otherwise the core scans the
// frames one at a time (one read port on the frame store), then runs the shared blend divider
// (skipped for a zero-length segment) and the shared multiplier when a segment brackets the
// time. A write word is taken only in idle, and busy holds until the result, so no new word
// is taken while an evaluation runs. The done strobe lasts one cycle and cannot be stalled.
// Reset clears frame_count and control; frame slots hold nothing defined until written.
`default_nettype none
module keyframe_linear_interpolator_core #(
	parameter int MAX_FRAMES = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire kli_pkg::req_t    req,
	output logic                  done,
	output kli_pkg::result_t      result,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import kli_pkg::*;

	localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int NW = $clog2(MAX_FRAMES + 1);

	frame_t             mem [MAX_FRAMES];
	frame_t             rd_data_q;
	frame_t             prev_q;
	frame_t             cur_q;
	state_t             state_q, state_d;
	logic [3:0]         frame_count_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      last_idx_q;
	logic               one_q;
	logic signed [31:0] q_q;
	logic [32:0]        rem_q;
	logic [32:0]        den_q;
	logic [BLEND_W-1:0] blend_q;
	logic [4:0]         cnt_q;
	logic [1:0]         ch_q;
	logic signed [50:0] prod_q;
	result_t            result_q;
	logic               done_q;

	logic               accept;
	logic               eval_go;
	logic [NW-1:0]      n_d;
	logic               first;
	logic               hit;
	logic               den_zero;
	logic               last;
	logic [33:0]        div_diff;
	logic signed [31:0] a_sel, b_sel;
	logic signed [32:0] span;
	logic signed [50:0] prod_d;
	logic signed [32:0] num_d;
	logic signed [32:0] den_d;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAME_COUNT) ? {28'd0, frame_count_q} : 32'd0;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= 4'd0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_COUNT) begin
			frame_count_q <= pwdata[3:0];
		end
	end

	always_comb begin
		if (int'(frame_count_q) > MAX_FRAMES) begin
			n_d = NW'(MAX_FRAMES);
		end else begin
			n_d = NW'(frame_count_q);
		end
	end

	always_comb begin
		accept   = start && !busy;
		eval_go  = accept && req.req_type == REQ_EVAL;
		first    = (idx_q == '0);
		hit      = (prev_q.t <= q_q) && (rd_data_q.t >= q_q);
		den_zero = (rd_data_q.t == prev_q.t);
		last     = (idx_q == last_idx_q);
		num_d    = {q_q[31], q_q} - {prev_q.t[31], prev_q.t};
		den_d    = {rd_data_q.t[31], rd_data_q.t} - {prev_q.t[31], prev_q.t};
		div_diff = {1'b0, rem_q} - {1'b0, den_q};
		case (ch_q)
			CH_X: begin
				a_sel = prev_q.x;
				b_sel = cur_q.x;
			end
			CH_Y: begin
				a_sel = prev_q.y;
				b_sel = cur_q.y;
			end
			default: begin
				a_sel = prev_q.angle;
				b_sel = cur_q.angle;
			end
		endcase
		span   = {b_sel[31], b_sel} - {a_sel[31], a_sel};
		prod_d = span * $signed({1'b0, blend_q});
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (eval_go && n_d != '0) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_GOT;
			end
			ST_GOT: begin
				if (first) begin
					state_d = one_q ? ST_IDLE : ST_RD;
				end else if (hit) begin
					state_d = den_zero ? ST_MUL : ST_DIV;
				end else begin
					state_d = last ? ST_IDLE : ST_RD;
				end
			end
			ST_DIV: begin
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				if (ch_q == CH_ANGLE) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_MUL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.req_type == REQ_WRITE && int'(req.frame_slot) < MAX_FRAMES) begin
			mem[AW'(req.frame_slot)] <= '{t: req.key_time, x: req.key_x,
				y: req.key_y, angle: req.key_angle};
		end
		rd_data_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_IDLE && eval_go && n_d == '0)
				|| (state_q == ST_GOT && first && one_q)
				|| (state_q == ST_GOT && !first && !hit && last)
				|| (state_q == ST_ADD && ch_q == CH_ANGLE);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (eval_go) begin
					q_q        <= req.query_time;
					idx_q      <= '0;
					one_q      <= (n_d == NW'(1));
					last_idx_q <= AW'(n_d - NW'(1));
					if (n_d == '0) begin
						result_q <= '{result_time: '0, result_x: '0, result_y: '0,
							result_angle: '0, result_case: CASE_EMPTY};
					end
				end
			end
			ST_GOT: begin
				if (first) begin
					prev_q <= rd_data_q;
					idx_q  <= AW'(1);
					if (one_q) begin
						result_q <= '{result_time: rd_data_q.t, result_x: rd_data_q.x,
							result_y: rd_data_q.y, result_angle: rd_data_q.angle,
							result_case: CASE_SINGLE};
					end
				end else if (hit) begin
					cur_q                <= rd_data_q;
					rem_q                <= num_d;
					den_q                <= den_d;
					blend_q              <= '0;
					cnt_q                <= 5'd0;
					ch_q                 <= CH_X;
					result_q.result_time <= q_q;
					result_q.result_case <= CASE_INTERP;
				end else if (last) begin
					result_q <= '{result_time: rd_data_q.t, result_x: rd_data_q.x,
						result_y: rd_data_q.y, result_angle: rd_data_q.angle,
						result_case: CASE_CLAMPED};
				end else begin
					prev_q <= rd_data_q;
					idx_q  <= idx_q + AW'(1);
				end
			end
			ST_DIV: begin
				blend_q <= {blend_q[BLEND_W-2:0], !div_diff[33]};
				rem_q   <= div_diff[33] ? {rem_q[31:0], 1'b0} : {div_diff[31:0], 1'b0};
				cnt_q   <= cnt_q + 5'd1;
			end
			ST_MUL: begin
				prod_q <= prod_d;
			end
			ST_ADD: begin
				case (ch_q)
					CH_X: begin
						result_q.result_x <= a_sel + prod_q[47:16];
					end
					CH_Y: begin
						result_q.result_y <= a_sel + prod_q[47:16];
					end
					default: begin
						result_q.result_angle <= a_sel + prod_q[47:16];
					end
				endcase
				ch_q <= ch_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
